FILE: sv/cmo_pkg.sv
// Shared types and constants for the cursor mask overlay pipeline.
package cmo_pkg;

	// Parameter defaults
	localparam int MAX_DIM_DEF     = 128;
	localparam int STORE_WORDS_DEF = 16384;

	// Fixed field widths
	localparam int PIX_W   = 32;
	localparam int COORD_W = 13;
	localparam int LADDR_W = 14;
	localparam int CFG_W   = 14;
	localparam int IDX_W   = 18;	// store word index, covers every pitch/row product
	localparam int ROW_W   = 9;	// shape row number, incl. the xor plane offset
	localparam int PROD_W  = 19;	// pitch times row
	localparam int SUM_W   = 20;	// byte or word address before the word split

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Shape kinds
	localparam logic KIND_MONO  = 1'b0;
	localparam logic KIND_COLOR = 1'b1;

	// Pixel constants
	localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hFF00_0000;
	localparam logic [PIX_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [PIX_W-1:0] RGB_MASK   = 32'h00FF_FFFF;
	localparam logic [PIX_W-1:0] ALL_ZERO   = 32'h0000_0000;

	// Register indexes
	typedef enum logic [2:0] {
		CFG_ENABLE = 3'd0,
		CFG_CURSOR_X = 3'd1,
		CFG_CURSOR_Y = 3'd2,
		CFG_KIND = 3'd3,
		CFG_WIDTH = 3'd4,
		CFG_HEIGHT = 3'd5,
		CFG_PITCH = 3'd6
	} cfg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic        overlay_enable;
		logic [13:0] cursor_x;
		logic [13:0] cursor_y;
		logic        shape_kind;
		logic [7:0]  shape_width;
		logic [8:0]  shape_height;
		logic [9:0]  shape_pitch;
	} cfg_t;

	// Address stage to store stage
	typedef struct packed {
		logic             is_load;
		logic             hit;
		logic [PIX_W-1:0] data;	// desktop pixel, or load word on a load
		logic [IDX_W-1:0] idx0;	// and plane / colour word / load target
		logic [IDX_W-1:0] idx1;	// xor plane
		logic [1:0]       lane0;
		logic [1:0]       lane1;
		logic [2:0]       bitpos;
	} req_t;

	// Store stage to blend stage
	typedef struct packed {
		logic             is_load;
		logic             hit;
		logic [PIX_W-1:0] data;
		logic [PIX_W-1:0] word0;
		logic [PIX_W-1:0] word1;
		logic             ok0;
		logic             ok1;
		logic [1:0]       lane0;
		logic [1:0]       lane1;
		logic [2:0]       bitpos;
	} rd_t;

endpackage

FILE: sv/cmo_addr.sv
// Offset, window test and shape address stages of the cursor overlay.
module cmo_addr #(
	parameter int MAX_CURSOR_DIM = cmo_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmo_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [cmo_pkg::LADDR_W-1:0]  load_addr,
	input  logic [cmo_pkg::PIX_W-1:0]    load_word,
	input  logic [cmo_pkg::COORD_W-1:0]  pix_x,
	input  logic [cmo_pkg::COORD_W-1:0]  pix_y,
	input  logic [cmo_pkg::PIX_W-1:0]    desk_pixel,
	output logic                         req_valid,
	input  logic                         req_ready,
	output cmo_pkg::req_t                req
);
	import cmo_pkg::*;

	localparam logic [9:0] MAXD = 10'(MAX_CURSOR_DIM);

	// Stage 1: offsets from the cursor origin
	logic                     v_s1, load_s1;
	logic [PIX_W-1:0]         data_s1;
	logic [LADDR_W-1:0]       laddr_s1;
	logic signed [14:0]       i_s1, j_s1;

	// Stage 2: window hit and row products
	logic                     v_s2, load_s2, hit_s2;
	logic [PIX_W-1:0]         data_s2;
	logic [LADDR_W-1:0]       laddr_s2;
	logic [7:0]               ui_s2;
	logic [PROD_W-1:0]        prod0_s2, prod1_s2;

	// Stage 3: word indexes
	logic                     v_s3;
	req_t                     req_s3;

	logic rdy1, rdy2, rdy3;
	logic signed [14:0] i_d, j_d;
	logic [9:0] w_lim, rows_raw, rows_lim;
	logic hit_d;
	logic [ROW_W-1:0] uj, row1;
	logic [9:0] stride;
	logic [PROD_W-1:0] prod0_d, prod1_d;
	logic [SUM_W-1:0] sum0, sum1;
	req_t req_d;

	// Per-stage flow control
	assign rdy3     = !v_s3 || req_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// Signed offsets
	assign i_d = $signed({2'b00, pix_x}) - $signed({cfg.cursor_x[13], cfg.cursor_x});
	assign j_d = $signed({2'b00, pix_y}) - $signed({cfg.cursor_y[13], cfg.cursor_y});

	// Visible area, clamped to the largest cursor
	always_comb begin
		w_lim    = ({2'b00, cfg.shape_width} > MAXD) ? MAXD : {2'b00, cfg.shape_width};
		rows_raw = (cfg.shape_kind == KIND_COLOR) ? {1'b0, cfg.shape_height}
			: {2'b00, cfg.shape_height[8:1]};
		rows_lim = (rows_raw > MAXD) ? MAXD : rows_raw;
		hit_d    = cfg.overlay_enable && !i_s1[14] && !j_s1[14]
			&& (i_s1[13:0] < {4'b0000, w_lim}) && (j_s1[13:0] < {4'b0000, rows_lim});
	end

	// Row products: and/colour row and xor-plane row
	always_comb begin
		uj      = {1'b0, j_s1[7:0]};
		row1    = {1'b0, j_s1[7:0]} + {1'b0, cfg.shape_height[8:1]};
		stride  = (cfg.shape_kind == KIND_COLOR) ? {2'b00, cfg.shape_pitch[9:2]}
			: cfg.shape_pitch;
		prod0_d = {9'd0, stride} * {10'd0, uj};
		prod1_d = {9'd0, stride} * {10'd0, row1};
	end

	// Column add and byte/word split
	always_comb begin
		sum0 = {1'b0, prod0_s2} + ((cfg.shape_kind == KIND_COLOR) ? {12'd0, ui_s2}
			: {15'd0, ui_s2[7:3]});
		sum1 = {1'b0, prod1_s2} + {15'd0, ui_s2[7:3]};
		req_d.is_load = load_s2;
		req_d.hit     = hit_s2;
		req_d.data    = data_s2;
		if (load_s2) begin
			req_d.idx0 = {{(IDX_W-LADDR_W){1'b0}}, laddr_s2};
		end else if (cfg.shape_kind == KIND_COLOR) begin
			req_d.idx0 = sum0[IDX_W-1:0];
		end else begin
			req_d.idx0 = sum0[SUM_W-1:2];
		end
		req_d.idx1   = sum1[SUM_W-1:2];
		req_d.lane0  = sum0[1:0];
		req_d.lane1  = sum1[1:0];
		req_d.bitpos = ui_s2[2:0];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (rdy1) begin
			load_s1  <= (cmd == CMD_LOAD);
			data_s1  <= (cmd == CMD_LOAD) ? load_word : desk_pixel;
			laddr_s1 <= load_addr;
			i_s1     <= i_d;
			j_s1     <= j_d;
		end
		if (rdy2) begin
			load_s2  <= load_s1;
			hit_s2   <= hit_d && !load_s1;
			data_s2  <= data_s1;
			laddr_s2 <= laddr_s1;
			ui_s2    <= i_s1[7:0];
			prod0_s2 <= prod0_d;
			prod1_s2 <= prod1_d;
		end
		if (rdy3) req_s3 <= req_d;
	end

	assign req_valid = v_s3;
	assign req       = req_s3;

endmodule

FILE: sv/cmo_store.sv
// Shape store and its registered read stage.
module cmo_store #(
	parameter int STORE_WORDS = cmo_pkg::STORE_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cmo_pkg::req_t req,
	output logic          rd_valid,
	input  logic          rd_ready,
	output cmo_pkg::rd_t  rd
);
	import cmo_pkg::*;

	localparam int AW = $clog2(STORE_WORDS);
	localparam logic [IDX_W-1:0] DEPTH = IDX_W'(STORE_WORDS);

	logic [PIX_W-1:0] mem [STORE_WORDS];

	logic             v_s4;
	logic             load_s4, hit_s4, ok0_s4, ok1_s4;
	logic [PIX_W-1:0] data_s4, word0_s4, word1_s4;
	logic [1:0]       lane0_s4, lane1_s4;
	logic [2:0]       bitpos_s4;

	logic rdy4, ok0, ok1, wr_en;

	assign rdy4      = !v_s4 || rd_ready;
	assign req_ready = rdy4;
	assign ok0       = req.idx0 < DEPTH;
	assign ok1       = req.idx1 < DEPTH;
	// Loads write in this stage so they stay ordered against pixel reads
	assign wr_en     = req_valid && rdy4 && req.is_load && ok0;

	// Store: one write port, two read ports, registered reads
	always_ff @(posedge clk) begin
		if (wr_en) mem[req.idx0[AW-1:0]] <= req.data;
		if (rdy4) begin
			word0_s4 <= mem[req.idx0[AW-1:0]];
			word1_s4 <= mem[req.idx1[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= req_valid;
		end
	end

	// Side data travelling with the read
	always_ff @(posedge clk) begin
		if (rdy4) begin
			load_s4   <= req.is_load;
			hit_s4    <= req.hit;
			data_s4   <= req.data;
			ok0_s4    <= ok0;
			ok1_s4    <= ok1;
			lane0_s4  <= req.lane0;
			lane1_s4  <= req.lane1;
			bitpos_s4 <= req.bitpos;
		end
	end

	assign rd_valid   = v_s4;
	assign rd.is_load = load_s4;
	assign rd.hit     = hit_s4;
	assign rd.data    = data_s4;
	assign rd.word0   = word0_s4;
	assign rd.word1   = word1_s4;
	assign rd.ok0     = ok0_s4;
	assign rd.ok1     = ok1_s4;
	assign rd.lane0   = lane0_s4;
	assign rd.lane1   = lane1_s4;
	assign rd.bitpos  = bitpos_s4;

endmodule

FILE: sv/cmo_blend.sv
// Mask/colour blend and output register of the cursor overlay.
module cmo_blend (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shape_kind,
	input  logic                      rd_valid,
	output logic                      rd_ready,
	input  cmo_pkg::rd_t              rd,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [cmo_pkg::PIX_W-1:0] out_pixel
);
	import cmo_pkg::*;

	logic             v_s5;
	logic [PIX_W-1:0] pix_s5;

	logic rdy5;
	logic [PIX_W-1:0] w0, w1, and32, xor32, mono_px, col_px, res;
	logic [7:0] byte0, byte1;
	logic and_bit, xor_bit;

	assign rdy5     = !v_s5 || out_ready;
	assign rd_ready = rdy5;

	// Out-of-range shape reads count as zero
	always_comb begin
		w0      = rd.ok0 ? rd.word0 : ALL_ZERO;
		w1      = rd.ok1 ? rd.word1 : ALL_ZERO;
		byte0   = 8'(w0 >> {rd.lane0, 3'b000});
		byte1   = 8'(w1 >> {rd.lane1, 3'b000});
		and_bit = byte0[3'd7 - rd.bitpos];
		xor_bit = byte1[3'd7 - rd.bitpos];
		and32   = and_bit ? ALL_ONES : ALPHA_MASK;
		xor32   = xor_bit ? RGB_MASK : ALL_ZERO;
		mono_px = (rd.data & and32) ^ xor32;
		col_px  = (|w0[31:24]) ? ((rd.data ^ w0) | ALPHA_MASK) : w0;
		if (!rd.hit) begin
			res = rd.data;
		end else if (shape_kind == KIND_COLOR) begin
			res = col_px;
		end else begin
			res = mono_px;
		end
	end

	// Output register; loads leave no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy5) begin
			v_s5 <= rd_valid && !rd.is_load;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) pix_s5 <= res;
	end

	assign out_valid = v_s5;
	assign out_pixel = pix_s5;

endmodule

FILE: sv/cursor_mask_overlay.sv
// A pixel transaction passes the register stages offset, window/row product, address, store
// read and blend before out_valid rises. Throughput: one transaction per cycle, loads
// included, while no result is held; the shape store write port sits in the same stage as
// its two read ports. A held result stalls each occupied stage behind it.
// Reset clears all valid bits and loads the register defaults; the shape store is not
// cleared and must be loaded before it is read.
module cursor_mask_overlay #(
	parameter int MAX_CURSOR_DIM = cmo_pkg::MAX_DIM_DEF,
	parameter int STORE_WORDS    = cmo_pkg::STORE_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [cmo_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [cmo_pkg::LADDR_W-1:0]  load_addr,
	input  logic [cmo_pkg::PIX_W-1:0]    load_word,
	input  logic [cmo_pkg::COORD_W-1:0]  pix_x,
	input  logic [cmo_pkg::COORD_W-1:0]  pix_y,
	input  logic [cmo_pkg::PIX_W-1:0]    desk_pixel,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cmo_pkg::PIX_W-1:0]    out_pixel
);
	import cmo_pkg::*;

	cfg_t cfg_q;
	logic req_valid, req_ready, rd_valid, rd_ready;
	req_t req;
	rd_t  rd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.overlay_enable <= 1'b0;
			cfg_q.cursor_x       <= 14'd0;
			cfg_q.cursor_y       <= 14'd0;
			cfg_q.shape_kind     <= KIND_MONO;
			cfg_q.shape_width    <= 8'd32;
			cfg_q.shape_height   <= 9'd64;
			cfg_q.shape_pitch    <= 10'd512;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:   cfg_q.overlay_enable <= cfg_data[0];
				CFG_CURSOR_X: cfg_q.cursor_x       <= cfg_data[13:0];
				CFG_CURSOR_Y: cfg_q.cursor_y       <= cfg_data[13:0];
				CFG_KIND:     cfg_q.shape_kind     <= cfg_data[0];
				CFG_WIDTH:    cfg_q.shape_width    <= cfg_data[7:0];
				CFG_HEIGHT:   cfg_q.shape_height   <= cfg_data[8:0];
				CFG_PITCH:    cfg_q.shape_pitch    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	cmo_addr #(
		.MAX_CURSOR_DIM(MAX_CURSOR_DIM)
	) u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.load_addr  (load_addr),
		.load_word  (load_word),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.desk_pixel (desk_pixel),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req)
	);

	cmo_store #(
		.STORE_WORDS(STORE_WORDS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rd_valid  (rd_valid),
		.rd_ready  (rd_ready),
		.rd        (rd)
	);

	cmo_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.shape_kind (cfg_q.shape_kind),
		.rd_valid   (rd_valid),
		.rd_ready   (rd_ready),
		.rd         (rd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_pixel  (out_pixel)
	);

	// An empty output register lets every stage move
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// The front can only stall when a result is held at the output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// A result appears only from a pixel transaction leaving the read stage
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(rd_valid && !rd.is_load))
		else $error("result without a pixel transaction behind it");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the cursor mask overlay: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
	import cmo_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int MAX_DIM      = MAX_DIM_DEF;
	localparam int STORE        = STORE_WORDS_DEF;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 300;
	localparam int RUN_LIMIT    = 400000;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 120;

	// One input transaction, every field present whatever the command
	typedef struct packed {
		logic               cmd;
		logic [LADDR_W-1:0] addr;
		logic [PIX_W-1:0]   word;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [PIX_W-1:0]   pixel;
	} xfer_t;

	// Directed table row: a register write or a transaction
	typedef struct {
		bit               is_write;
		cfg_idx_t         reg_sel;
		logic [CFG_W-1:0] reg_val;
		xfer_t            xfer;
		bit               fixed;
		logic [PIX_W-1:0] fixed_out;
	} plan_row_t;

	// Where a pixel lands in the cursor and which store words it reads
	typedef struct {
		bit hit;
		int ui;
		int addr0;	// mono: AND byte address; colour: word index
		int word0;
		int word1;
	} shape_ref_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_BEAT, RX_SPARSE} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [LADDR_W-1:0] load_addr;
	logic [PIX_W-1:0]   load_word;
	logic [COORD_W-1:0] pix_x;
	logic [COORD_W-1:0] pix_y;
	logic [PIX_W-1:0]   desk_pixel;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PIX_W-1:0]   out_pixel;

	// Predictor state
	cfg_t             settings;
	logic [PIX_W-1:0] shape_mem [STORE];
	bit               shape_known [STORE];

	logic [PIX_W-1:0] pending_pixels [$];
	plan_row_t        plan [$];
	int               errors = 0;
	int               cycle_count = 0;
	int               burst_left = 0;
	bit               steady_send = 1'b0;

	// Receiver pacing
	int       hold_asks = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	cursor_mask_overlay dut (.*);

	always #(HALF_PERIOD) clk = ~clk;

	// Clamped visible columns and rows
	function automatic void visible_span(output int cols, output int rows);
		cols = int'(settings.shape_width);
		rows = (settings.shape_kind == KIND_COLOR) ? int'(settings.shape_height)
			: int'(settings.shape_height >> 1);
		if (cols > MAX_DIM) cols = MAX_DIM;
		if (rows > MAX_DIM) rows = MAX_DIM;
	endfunction

	function automatic shape_ref_t shape_ref(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
		shape_ref_t r;
		int cols, rows, i, j, pitch, addr1;
		visible_span(cols, rows);
		i = int'(px) - int'($signed(settings.cursor_x));
		j = int'(py) - int'($signed(settings.cursor_y));
		pitch = int'(settings.shape_pitch);
		r.ui = i;
		r.hit = settings.overlay_enable && i >= 0 && j >= 0 && i < cols && j < rows;
		if (settings.shape_kind == KIND_MONO) begin
			r.addr0 = (i >> 3) + pitch * j;
			addr1 = (i >> 3) + pitch * (j + int'(settings.shape_height >> 1));
			r.word0 = r.addr0 >> 2;
			r.word1 = addr1 >> 2;
		end else begin
			r.addr0 = i + (pitch >> 2) * j;
			r.word0 = r.addr0;
			r.word1 = r.addr0;
		end
		return r;
	endfunction

	// Words past the end of the store read as zero
	function automatic logic [PIX_W-1:0] shape_word(int idx);
		return (idx < STORE) ? shape_mem[idx] : ALL_ZERO;
	endfunction

	// Expected pixel after the cursor is applied
	function automatic logic [PIX_W-1:0] overlay_pixel(xfer_t t);
		shape_ref_t r;
		logic [PIX_W-1:0] sw, and_m, xor_m;
		logic [7:0] sel, and_b, xor_b;
		int xor_addr;
		r = shape_ref(t.px, t.py);
		if (!r.hit) return t.pixel;
		if (settings.shape_kind == KIND_MONO) begin
			sel = 8'h80 >> (r.ui & 7);
			xor_addr = (r.ui >> 3) + int'(settings.shape_pitch)
				* (int'(t.py) - int'($signed(settings.cursor_y))
				+ int'(settings.shape_height >> 1));
			and_b = 8'(shape_word(r.word0) >> (8 * (r.addr0 & 3)));
			xor_b = 8'(shape_word(r.word1) >> (8 * (xor_addr & 3)));
			and_m = ((and_b & sel) != 0) ? ALL_ONES : ALPHA_MASK;
			xor_m = ((xor_b & sel) != 0) ? RGB_MASK : ALL_ZERO;
			return (t.pixel & and_m) ^ xor_m;
		end
		sw = shape_word(r.word0);
		return ((sw & ALPHA_MASK) != 0) ? ((t.pixel ^ sw) | ALPHA_MASK) : sw;
	endfunction

	function automatic int coord_pick();
		case ($urandom_range(0, 5))
			0: return -8192;
			1: return 8191;
			2: return -int'($urandom_range(0, 40));
			3: return int'($urandom_range(8100, 8191));
			default: return int'($urandom_range(0, 8000));
		endcase
	endfunction

	function automatic cfg_t pick_settings(int phase);
		cfg_t s;
		s.overlay_enable = (phase == 1) ? 1'b0 : ($urandom_range(0, 7) != 0);
		s.shape_kind = (phase % 2 == 1) ? KIND_COLOR : KIND_MONO;
		s.cursor_x = 14'(coord_pick());
		s.cursor_y = 14'(coord_pick());
		case ($urandom_range(0, 5))
			0: s.shape_width = 8'd0;
			1: s.shape_width = 8'($urandom_range(1, 8));
			2: s.shape_width = 8'($urandom_range(9, 40));
			3: s.shape_width = 8'd128;
			4: s.shape_width = 8'd255;
			default: s.shape_width = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 5))
			0: s.shape_height = 9'd0;
			1: s.shape_height = 9'($urandom_range(1, 16));
			2: s.shape_height = 9'($urandom_range(17, 80));
			3: s.shape_height = 9'd256;
			4: s.shape_height = 9'd511;
			default: s.shape_height = 9'($urandom_range(0, 511));
		endcase
		case ($urandom_range(0, 5))
			0: s.shape_pitch = 10'd0;
			1: s.shape_pitch = 10'($urandom_range(1, 7));
			2: s.shape_pitch = 10'(4 * $urandom_range(1, 32));
			3: s.shape_pitch = 10'd512;
			4: s.shape_pitch = 10'd1023;
			default: s.shape_pitch = 10'($urandom_range(0, 1023));
		endcase
		return s;
	endfunction

	// Register write, mirrored into the predictor
	task automatic write_reg(cfg_idx_t sel, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (sel)
			CFG_ENABLE:   settings.overlay_enable = v[0];
			CFG_CURSOR_X: settings.cursor_x = v;
			CFG_CURSOR_Y: settings.cursor_y = v;
			CFG_KIND:     settings.shape_kind = v[0];
			CFG_WIDTH:    settings.shape_width = v[7:0];
			CFG_HEIGHT:   settings.shape_height = v[8:0];
			CFG_PITCH:    settings.shape_pitch = v[9:0];
			default: ;
		endcase
	endtask

	// Offer one transaction in bursts with random gaps, then account for it
	task automatic send_xfer(xfer_t t, bit fixed, logic [PIX_W-1:0] fixed_out);
		int gap;
		bit took;
		if (burst_left == 0) begin
			gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= t.cmd;
		load_addr <= t.addr;
		load_word <= t.word;
		pix_x <= t.px;
		pix_y <= t.py;
		desk_pixel <= t.pixel;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		if (t.cmd == CMD_LOAD) begin
			shape_mem[t.addr] = t.word;
			shape_known[t.addr] = 1'b1;
		end else begin
			pending_pixels = {pending_pixels, (fixed ? fixed_out : overlay_pixel(t))};
		end
	endtask

	// Stop offering and wait until the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic plan_write(cfg_idx_t sel, logic [CFG_W-1:0] v);
		plan_row_t row;
		row.is_write = 1'b1;
		row.reg_sel = sel;
		row.reg_val = v;
		row.xfer = '0;
		row.fixed = 1'b0;
		row.fixed_out = '0;
		plan = {plan, row};
	endtask

	task automatic plan_xfer(logic c, logic [LADDR_W-1:0] a, logic [PIX_W-1:0] w,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [PIX_W-1:0] p,
			bit fixed, logic [PIX_W-1:0] fixed_out);
		plan_row_t row;
		row.is_write = 1'b0;
		row.reg_sel = CFG_ENABLE;
		row.reg_val = '0;
		row.xfer = '{cmd: c, addr: a, word: w, px: x, py: y, pixel: p};
		row.fixed = fixed;
		row.fixed_out = fixed_out;
		plan = {plan, row};
	endtask

	// Receiver: changing stall patterns, plus one long hold on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			rx_tick++;
			case (rx_mode)
				RX_OPEN:  out_ready <= 1'b1;
				RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
				RX_BEAT:  out_ready <= (rx_tick % 4 != 0);
				default:  out_ready <= (rx_tick % 4 == 0);
			endcase
		end
	end

	// Result check, sampled mid-cycle where everything is stable
	always @(negedge clk) begin
		logic [PIX_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: out_pixel %h with nothing expected", $time, out_pixel);
			end else begin
				want = pending_pixels.pop_front();
				if (out_pixel !== want) begin
					errors++;
					$display("%0t: out_pixel expected %h, got %h", $time, want, out_pixel);
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		xfer_t t, fill;
		shape_ref_t r;
		cfg_t s;
		int cols, rows, ci, cj, sent;
		int need [2];
		bit dirty;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ENABLE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_LOAD;
		load_addr <= '0;
		load_word <= '0;
		pix_x <= '0;
		pix_y <= '0;
		desk_pixel <= '0;
		settings = '{overlay_enable: 1'b0, cursor_x: '0, cursor_y: '0, shape_kind: KIND_MONO,
			shape_width: 8'd32, shape_height: 9'd64, shape_pitch: 10'd512};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disabled after reset: pixels pass, load fields ignored
		plan_xfer(CMD_PIXEL, '0, '0, '0, '0, ALL_ZERO, 1, ALL_ZERO);
		plan_xfer(CMD_PIXEL, 14'h3FFF, ALL_ONES, 13'h1FFF, 13'h1FFF, ALL_ONES, 1, ALL_ONES);
		// Shape loads with the pixel fields at both extremes
		plan_xfer(CMD_LOAD, 14'd0, 32'hA5A5_0F0F, 13'h1FFF, 13'h1FFF, ALL_ONES, 0, ALL_ZERO);
		plan_xfer(CMD_LOAD, 14'h3FFF, ALL_ONES, '0, '0, ALL_ZERO, 0, ALL_ZERO);
		plan_xfer(CMD_LOAD, 14'd1, 32'h0000_FFFF, 13'd5, 13'd9, 32'h1111_2222, 0, ALL_ZERO);
		plan_xfer(CMD_LOAD, 14'd2, 32'h3C3C_F0F0, 13'd7, 13'd3, 32'h3333_4444, 0, ALL_ZERO);
		plan_xfer(CMD_LOAD, 14'd3, 32'hFFFF_0000, 13'd1, 13'd2, 32'h5555_6666, 0, ALL_ZERO);
		plan_xfer(CMD_LOAD, 14'd127, 32'h8000_0001, 13'd0, 13'd0, ALL_ZERO, 0, ALL_ZERO);
		// Small monochrome cursor at (100, 200): two visible rows
		plan_write(CFG_ENABLE, 14'd1);
		plan_write(CFG_CURSOR_X, 14'd100);
		plan_write(CFG_CURSOR_Y, 14'd200);
		plan_write(CFG_KIND, CFG_W'(KIND_MONO));
		plan_write(CFG_WIDTH, 14'd16);
		plan_write(CFG_HEIGHT, 14'd4);
		plan_write(CFG_PITCH, 14'd4);
		plan_xfer(CMD_PIXEL, 14'h1234, 32'h0F0F_0F0F, 13'd100, 13'd200, 32'h1234_5678, 0, '0);
		plan_xfer(CMD_PIXEL, 14'h0001, ALL_ZERO, 13'd107, 13'd200, 32'h89AB_CDEF, 0, '0);
		plan_xfer(CMD_PIXEL, 14'h2222, ALL_ONES, 13'd108, 13'd201, ALL_ZERO, 0, '0);
		plan_xfer(CMD_PIXEL, 14'h0F0F, 32'h5A5A_5A5A, 13'd115, 13'd201, ALL_ONES, 0, '0);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd99, 13'd200, 32'hCAFE_F00D, 1, 32'hCAFE_F00D);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd116, 13'd201, 32'h0BAD_BEEF, 1, 32'h0BAD_BEEF);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd100, 13'd202, 32'h7654_3210, 1, 32'h7654_3210);
		// Rows far down land past the store and read as zero
		plan_write(CFG_HEIGHT, 14'd256);
		plan_write(CFG_PITCH, 14'd1023);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd103, 13'd300, 32'h1234_5678, 1, 32'h1200_0000);
		// Masked colour; pitch 6 truncates to a one-word stride
		plan_write(CFG_KIND, CFG_W'(KIND_COLOR));
		plan_write(CFG_HEIGHT, 14'd2);
		plan_write(CFG_PITCH, 14'd6);
		plan_write(CFG_WIDTH, 14'd2);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd100, 13'd200, 32'h1122_3344, 0, '0);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd101, 13'd200, 32'h5566_7788, 1, 32'h0000_FFFF);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd101, 13'd201, 32'h9ABC_DEF0, 0, '0);
		// Zero pitch: every row reads row zero
		plan_write(CFG_PITCH, 14'd0);
		plan_write(CFG_HEIGHT, 14'd8);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd101, 13'd207, 32'h0102_0304, 0, '0);
		// Oversized shape is clamped to the maximum size
		plan_write(CFG_WIDTH, 14'd255);
		plan_write(CFG_HEIGHT, 14'd511);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd227, 13'd327, 32'h4433_2211, 0, '0);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd228, 13'd200, 32'hDEAD_BEEF, 1, 32'hDEAD_BEEF);
		plan_xfer(CMD_PIXEL, '0, '0, 13'd100, 13'd328, 32'hFACE_0FF0, 1, 32'hFACE_0FF0);
		// Cursor at the negative extreme never reaches the desktop
		plan_write(CFG_KIND, CFG_W'(KIND_MONO));
		plan_write(CFG_CURSOR_X, 14'h2000);
		plan_write(CFG_CURSOR_Y, 14'h2000);
		plan_xfer(CMD_PIXEL, '0, '0, 13'h1FFF, 13'h1FFF, 32'h1357_9BDF, 1, 32'h1357_9BDF);
		// Cursor at the far corner covers the last pixel
		plan_write(CFG_CURSOR_X, 14'h1FFF);
		plan_write(CFG_CURSOR_Y, 14'h1FFF);
		plan_xfer(CMD_PIXEL, '0, '0, 13'h1FFF, 13'h1FFF, 32'h2468_ACE0, 0, '0);

		dirty = 1'b0;
		foreach (plan[k]) begin
			if (plan[k].is_write) begin
				if (dirty) begin
					settle();
					dirty = 1'b0;
				end
				write_reg(plan[k].reg_sel, plan[k].reg_val);
			end else begin
				send_xfer(plan[k].xfer, plan[k].fixed, plan[k].fixed_out);
				dirty = 1'b1;
			end
		end

		// Random phases, each under its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			s = pick_settings(phase);
			write_reg(CFG_ENABLE, CFG_W'(s.overlay_enable));
			write_reg(CFG_CURSOR_X, s.cursor_x);
			write_reg(CFG_CURSOR_Y, s.cursor_y);
			write_reg(CFG_KIND, CFG_W'(s.shape_kind));
			write_reg(CFG_WIDTH, CFG_W'(s.shape_width));
			write_reg(CFG_HEIGHT, CFG_W'(s.shape_height));
			write_reg(CFG_PITCH, CFG_W'(s.shape_pitch));
			// One phase runs back to back against a long output hold
			if (phase == 4) begin
				steady_send = 1'b1;
				hold_asks <= hold_asks + 1;
			end
			visible_span(cols, rows);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				t.cmd = CMD_PIXEL;
				t.addr = LADDR_W'($urandom);
				t.word = $urandom;
				t.px = COORD_W'($urandom);
				t.py = COORD_W'($urandom);
				case ($urandom_range(0, 15))
					0: t.pixel = ALL_ZERO;
					1: t.pixel = ALL_ONES;
					default: t.pixel = $urandom;
				endcase
				if ($urandom_range(0, 6) == 0) begin
					// stray load anywhere in the store
					t.cmd = CMD_LOAD;
				end else if ($urandom_range(0, 3) != 0) begin
					// aim at the cursor window and its border
					ci = int'($signed(settings.cursor_x)) + int'($urandom_range(0, cols + 3)) - 2;
					cj = int'($signed(settings.cursor_y)) + int'($urandom_range(0, rows + 3)) - 2;
					if (ci < 0 || ci > 8191) ci = $urandom_range(0, 8191);
					if (cj < 0 || cj > 8191) cj = $urandom_range(0, 8191);
					t.px = COORD_W'(ci);
					t.py = COORD_W'(cj);
				end
				if (t.cmd == CMD_PIXEL) begin
					// load any shape word the pixel reads that was never written
					r = shape_ref(t.px, t.py);
					if (r.hit) begin
						need[0] = r.word0;
						need[1] = r.word1;
						foreach (need[n]) begin
							if (need[n] < STORE && !shape_known[need[n]]) begin
								fill = t;
								fill.cmd = CMD_LOAD;
								fill.addr = LADDR_W'(need[n]);
								fill.word = $urandom;
								send_xfer(fill, 1'b0, ALL_ZERO);
								sent++;
							end
						end
					end
				end
				send_xfer(t, 1'b0, ALL_ZERO);
				sent++;
			end
			steady_send = 1'b0;
		end

		settle();
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/cmo_pkg.sv
sv/cmo_addr.sv
sv/cmo_store.sv
sv/cmo_blend.sv
sv/cursor_mask_overlay.sv
tb/testbench.sv
